// ===== src/gksr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gksr_pkg
// Shared widths, codes, states and the exp table of the spike-rate estimator.
// ----------------------------------------------------------------------------
package gksr_pkg;

    // ring and table depths are powers of two
    localparam int RING_DEPTH      = 64;
    localparam int RING_IDX_W      = $clog2(RING_DEPTH);
    localparam int CNT_W           = RING_IDX_W + 1;
    localparam int EXP_TABLE_DEPTH = 1024;
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
    localparam int TIME_BITS       = 48;

    localparam int CMD_W     = 2;
    localparam int DT_W      = 24;
    localparam int WIN_W     = 24;
    localparam int SCALE_W   = 24;
    localparam int GAIN_W    = 24;
    localparam int NCNT_W    = 16;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int RATE_W    = 32;
    localparam int USED_W    = 7;
    localparam int ENTRY_W   = 16;
    localparam int ARG_W     = 16;
    localparam int TERM_W    = GAIN_W + ENTRY_W;
    localparam int SUM_W     = TERM_W + CNT_W;
    localparam int RATE_SHIFT = 15;

    localparam logic [WIN_W-1:0]   WIN_RESET   = 24'd314573;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd51236;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd231705;
    localparam logic [NCNT_W-1:0]  NCNT_RESET  = 16'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_FIRE  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW = 2'd0,
        REG_SCALE  = 2'd1,
        REG_GAIN   = 2'd2,
        REG_NCOUNT = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DIVIDE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [NCNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

    typedef logic [EXP_TABLE_DEPTH-1:0][ENTRY_W-1:0] exp_rom_t;

    // exp(-16*i/depth) in Q1.15: series through the sixth power on y/256, then squared eight times
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [63:0] y;
        logic [63:0] s;
        logic [63:0] t;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            y = (64'(i) << 26) / EXP_TABLE_DEPTH;
            s = 64'd1 << 30;
            t = 64'd1 << 30;
            t = (t * y) >> 30;
            s = s - t;
            t = ((t * y) >> 30) / 2;
            s = s + t;
            t = ((t * y) >> 30) / 3;
            s = s - t;
            t = ((t * y) >> 30) / 4;
            s = s + t;
            t = ((t * y) >> 30) / 5;
            s = s - t;
            t = ((t * y) >> 30) / 6;
            s = s + t;
            for (int k = 0; k < 8; k++) begin
                s = (s * s) >> 30;
            end
            rom[i] = ENTRY_W'((s + (64'd1 << 14)) >> 15);
        end
        return rom;
    endfunction

endpackage

// ===== src/gksr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gksr_div
// Restoring divider of the kernel sum by the neuron count, one bit per cycle.
// ----------------------------------------------------------------------------
module gksr_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  gksr_pkg::div_req_t  req,
    output gksr_pkg::div_rsp_t  rsp
);

    localparam int STEP_W = $clog2(gksr_pkg::SUM_W + 1);

    logic [gksr_pkg::NCNT_W-1:0] rem_reg, rem_next;
    logic [gksr_pkg::SUM_W-1:0]  quo_reg, quo_next;
    logic [gksr_pkg::NCNT_W-1:0] div_reg, div_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    logic [gksr_pkg::NCNT_W:0]   rem_sh;
    logic                        fits;

    always_comb begin
        rem_sh    = {rem_reg, quo_reg[gksr_pkg::SUM_W-1]};
        fits      = rem_sh >= {1'b0, div_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            div_next  = req.divisor;
            step_next = STEP_W'(gksr_pkg::SUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? gksr_pkg::NCNT_W'(rem_sh - {1'b0, div_reg})
                             : rem_sh[gksr_pkg::NCNT_W-1:0];
            quo_next  = {quo_reg[gksr_pkg::SUM_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== src/gaussian_kernel_spike_rate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_kernel_spike_rate
// Spike-rate estimator: ring of spike times, gaussian kernel sum, divide.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                 | tuser
//  s_       | in        | dt[23:0]                           | command[1:0], enabled[2]
//  m_       | out       | firing_rate[31:0], spikes[38:32]   | overflow[0]
//  cfg_     | in        | index, write data, write enable    | -
//
// fire, unused codes and a suppressed tick are handled in idle; a clear passes
// through the result state before the next request.
// an enabled tick walks the ring, one entry read per cycle from the ring memory,
// through a six-stage kernel pipeline, then the divider divides the sum by the count.
// reset is synchronous; the ring memory needs no clearing pass.
// a result waiting on m_tready holds the block in its result state.
// ----------------------------------------------------------------------------
module gaussian_kernel_spike_rate (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // dt
    input  logic [2:0]                     s_tuser,   // command, enabled
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [39:0]                    m_tdata,   // firing_rate, spikes_in_window
    output logic [0:0]                     m_tuser,   // overflow
    input  logic                           cfg_wr_en,
    input  logic [gksr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gksr_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam gksr_pkg::exp_rom_t EXP_ROM = gksr_pkg::build_exp_rom();
    localparam int PROD_W = gksr_pkg::WIN_W + gksr_pkg::SCALE_W;
    localparam int QSH_W  = gksr_pkg::SUM_W - gksr_pkg::RATE_SHIFT;

    gksr_pkg::state_t state_reg, state_next;

    logic [gksr_pkg::WIN_W-1:0]     win_reg;
    logic [gksr_pkg::SCALE_W-1:0]   scale_reg;
    logic [gksr_pkg::GAIN_W-1:0]    gain_reg;
    logic [gksr_pkg::NCNT_W-1:0]    ncnt_reg;

    logic [gksr_pkg::TIME_BITS-1:0]  ct_reg, ct_next;
    logic [gksr_pkg::RING_IDX_W-1:0] oldest_reg, oldest_next;
    logic [gksr_pkg::CNT_W-1:0]      count_reg, count_next;
    logic                            ovf_reg, ovf_next;

    logic [gksr_pkg::CNT_W-1:0]      j_reg, j_next;
    logic                            stop_reg, stop_next;
    logic                            rd_vld_reg;
    logic [gksr_pkg::TIME_BITS-1:0]  rd_q_reg;
    logic [gksr_pkg::RING_IDX_W-1:0] rd_addr, wr_addr;
    logic                            issue, wr_en;

    logic [gksr_pkg::TIME_BITS-1:0] ring_mem [gksr_pkg::RING_DEPTH];

    logic [gksr_pkg::WIN_W-1:0]   a_tau_reg;
    logic                         a_vld_reg;
    logic [2*gksr_pkg::WIN_W-1:0] b_t2_reg;
    logic                         b_vld_reg;
    logic [PROD_W-1:0]            c_hi_reg, c_lo_reg;
    logic                         c_vld_reg;
    logic [gksr_pkg::ENTRY_W-1:0] rom_q_reg;
    logic                         e_vld_reg;
    logic [gksr_pkg::TERM_W-1:0]  f_term_reg;
    logic                         f_vld_reg;
    logic [gksr_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [gksr_pkg::USED_W-1:0]  used_reg, used_next;

    logic [gksr_pkg::TIME_BITS-1:0] tau_full;
    logic                           a_live, in_win, stale;
    logic [PROD_W:0]                arg_full;
    logic [PROD_W-16:0]             arg;
    logic                           arg_ok;
    logic [gksr_pkg::EXP_IDX_W-1:0] rom_idx;
    logic                           pipe_empty;

    logic [gksr_pkg::RATE_W-1:0] res_rate_reg, res_rate_next;
    logic [gksr_pkg::USED_W-1:0] res_used_reg, res_used_next;
    logic                        m_vld_reg, m_vld_next;
    logic [gksr_pkg::RATE_W-1:0] m_rate_reg;
    logic [gksr_pkg::USED_W-1:0] m_used_reg;
    logic                        m_ovf_reg;
    logic                        m_load;

    logic              s_acc, tick_go;
    gksr_pkg::cmd_t    cmd;
    logic [QSH_W-1:0]  q_sh;

    gksr_pkg::div_req_t div_req;
    gksr_pkg::div_rsp_t div_rsp;

    assign s_acc   = s_tvalid && s_tready;
    assign cmd     = gksr_pkg::cmd_t'(s_tuser[1:0]);
    assign tick_go = s_acc && cmd == gksr_pkg::CMD_TICK && s_tuser[2] && ncnt_reg != '0;

    // age check on the word just read from the ring
    assign tau_full = ct_reg - rd_q_reg;
    assign in_win   = tau_full < {{(gksr_pkg::TIME_BITS - gksr_pkg::WIN_W){1'b0}}, win_reg};
    assign a_live   = rd_vld_reg && !stop_reg;
    assign stale    = a_live && !in_win;

    assign issue   = state_reg == gksr_pkg::ST_WALK && j_reg != '0 && !stop_reg && !stale;
    assign rd_addr = oldest_reg + j_reg[gksr_pkg::RING_IDX_W-1:0] - 1'b1;
    assign wr_addr = oldest_reg + count_reg[gksr_pkg::RING_IDX_W-1:0];
    assign wr_en   = s_acc && cmd == gksr_pkg::CMD_FIRE
                     && count_reg < gksr_pkg::CNT_W'(gksr_pkg::RING_DEPTH);

    // q4.12 argument from the two partial products
    assign arg_full = {1'b0, c_hi_reg} + {{(PROD_W - 23){1'b0}}, c_lo_reg[PROD_W-1:24]};
    assign arg      = arg_full[PROD_W:16];
    assign arg_ok   = arg[PROD_W-16:gksr_pkg::ARG_W] == '0;
    assign rom_idx  = arg[gksr_pkg::ARG_W-1:gksr_pkg::ARG_W-gksr_pkg::EXP_IDX_W];

    assign pipe_empty = !(rd_vld_reg || a_vld_reg || b_vld_reg || c_vld_reg
                          || e_vld_reg || f_vld_reg);

    assign q_sh = div_rsp.quotient[gksr_pkg::SUM_W-1:gksr_pkg::RATE_SHIFT];

    assign div_req.start    = state_reg == gksr_pkg::ST_DRAIN && pipe_empty;
    assign div_req.dividend = sum_reg;
    assign div_req.divisor  = ncnt_reg;

    gksr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gksr_pkg::ST_IDLE: begin
                if (tick_go) begin
                    state_next = gksr_pkg::ST_WALK;
                end else if (s_acc && cmd == gksr_pkg::CMD_CLEAR) begin
                    state_next = gksr_pkg::ST_RESULT;
                end
            end
            gksr_pkg::ST_WALK: begin
                if (!issue) begin
                    state_next = gksr_pkg::ST_DRAIN;
                end
            end
            gksr_pkg::ST_DRAIN: begin
                if (pipe_empty) begin
                    state_next = gksr_pkg::ST_DIVIDE;
                end
            end
            gksr_pkg::ST_DIVIDE: begin
                if (div_rsp.done) begin
                    state_next = gksr_pkg::ST_RESULT;
                end
            end
            gksr_pkg::ST_RESULT: begin
                if (!m_vld_reg || m_tready) begin
                    state_next = gksr_pkg::ST_IDLE;
                end
            end
            default: state_next = gksr_pkg::ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        s_tready = state_reg == gksr_pkg::ST_IDLE;
        m_load   = state_reg == gksr_pkg::ST_RESULT && (!m_vld_reg || m_tready);
    end

    // ring bookkeeping and walk control
    always_comb begin
        ct_next       = ct_reg;
        oldest_next   = oldest_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        j_next        = j_reg;
        stop_next     = stop_reg;
        sum_next      = sum_reg;
        used_next     = used_reg;
        res_rate_next = res_rate_reg;
        res_used_next = res_used_reg;
        if (s_acc) begin
            case (cmd)
                gksr_pkg::CMD_TICK: begin
                    ct_next = ct_reg + {{(gksr_pkg::TIME_BITS - gksr_pkg::DT_W){1'b0}}, s_tdata};
                end
                gksr_pkg::CMD_FIRE: begin
                    if (wr_en) begin
                        count_next = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                gksr_pkg::CMD_CLEAR: begin
                    oldest_next   = '0;
                    count_next    = '0;
                    res_rate_next = '0;
                    res_used_next = '0;
                end
                default: ;
            endcase
        end
        if (tick_go) begin
            j_next    = count_reg;
            stop_next = 1'b0;
            sum_next  = '0;
            used_next = '0;
        end else begin
            if (issue) begin
                j_next = j_reg - 1'b1;
            end
            if (a_live && in_win) begin
                used_next = used_reg + 1'b1;
            end
            // first stale entry: drop only the oldest and stop the walk
            if (stale) begin
                stop_next   = 1'b1;
                oldest_next = oldest_reg + 1'b1;
                count_next  = count_reg - 1'b1;
            end
            if (f_vld_reg) begin
                sum_next = sum_reg + {{(gksr_pkg::SUM_W - gksr_pkg::TERM_W){1'b0}}, f_term_reg};
            end
        end
        if (div_rsp.done) begin
            res_rate_next = (q_sh > QSH_W'({gksr_pkg::RATE_W{1'b1}}))
                            ? {gksr_pkg::RATE_W{1'b1}} : gksr_pkg::RATE_W'(q_sh);
            res_used_next = used_reg;
        end
    end

    always_comb begin
        m_vld_next = m_vld_reg;
        if (m_load) begin
            m_vld_next = 1'b1;
        end else if (m_tready) begin
            m_vld_next = 1'b0;
        end
    end

    // ring memory, one read and one write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= ct_reg;
        end
        rd_q_reg <= ring_mem[rd_addr];
    end

    // kernel pipeline payload
    always_ff @(posedge aclk) begin
        a_tau_reg  <= tau_full[gksr_pkg::WIN_W-1:0];
        b_t2_reg   <= a_tau_reg * a_tau_reg;
        c_hi_reg   <= b_t2_reg[2*gksr_pkg::WIN_W-1:gksr_pkg::WIN_W] * scale_reg;
        c_lo_reg   <= b_t2_reg[gksr_pkg::WIN_W-1:0] * scale_reg;
        rom_q_reg  <= EXP_ROM[rom_idx];
        f_term_reg <= gain_reg * rom_q_reg;
        sum_reg    <= sum_next;
        used_reg   <= used_next;
        j_reg      <= j_next;
        res_rate_reg <= res_rate_next;
        res_used_reg <= res_used_next;
        if (m_load) begin
            m_rate_reg <= res_rate_reg;
            m_used_reg <= res_used_reg;
            m_ovf_reg  <= ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= gksr_pkg::ST_IDLE;
            ct_reg     <= '0;
            oldest_reg <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            stop_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            c_vld_reg  <= 1'b0;
            e_vld_reg  <= 1'b0;
            f_vld_reg  <= 1'b0;
            m_vld_reg  <= 1'b0;
            win_reg    <= gksr_pkg::WIN_RESET;
            scale_reg  <= gksr_pkg::SCALE_RESET;
            gain_reg   <= gksr_pkg::GAIN_RESET;
            ncnt_reg   <= gksr_pkg::NCNT_RESET;
        end else begin
            state_reg  <= state_next;
            ct_reg     <= ct_next;
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            stop_reg   <= stop_next;
            rd_vld_reg <= issue;
            a_vld_reg  <= a_live && in_win;
            b_vld_reg  <= a_vld_reg;
            c_vld_reg  <= b_vld_reg;
            e_vld_reg  <= c_vld_reg && arg_ok;
            f_vld_reg  <= e_vld_reg;
            m_vld_reg  <= m_vld_next;
            if (cfg_wr_en) begin
                case (gksr_pkg::reg_idx_t'(cfg_index))
                    gksr_pkg::REG_WINDOW: win_reg   <= cfg_wdata[gksr_pkg::WIN_W-1:0];
                    gksr_pkg::REG_SCALE:  scale_reg <= cfg_wdata[gksr_pkg::SCALE_W-1:0];
                    gksr_pkg::REG_GAIN:   gain_reg  <= cfg_wdata[gksr_pkg::GAIN_W-1:0];
                    gksr_pkg::REG_NCOUNT: ncnt_reg  <= cfg_wdata[gksr_pkg::NCNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {1'b0, m_used_reg, m_rate_reg};
    assign m_tuser  = m_ovf_reg;

endmodule

// ===== src/gksr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gksr_checker
// Port-level checks of the spike-rate estimator, bound to the top level.
// ----------------------------------------------------------------------------
module gksr_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [23:0]                    s_tdata,
    input logic [2:0]                     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [39:0]                    m_tdata,
    input logic [0:0]                     m_tuser,
    input logic                           cfg_wr_en,
    input logic [gksr_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [gksr_pkg::CFG_W-1:0]     cfg_wdata
);

    logic ovf_seen_reg;

    // overflow once reported stays set until reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_seen_reg <= 1'b0;
        end else if (m_tvalid && m_tready && m_tuser[0]) begin
            ovf_seen_reg <= 1'b1;
        end
    end

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ovf_seen_reg |-> m_tuser[0])
        else $error("overflow flag dropped");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[38:32] == 7'd0 |-> m_tdata[31:0] == 32'd0)
        else $error("nonzero rate with no spikes in window");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[38:32] <= 7'(gksr_pkg::RING_DEPTH))
        else $error("spike count beyond ring depth");

endmodule

bind gaussian_kernel_spike_rate gksr_checker u_gksr_checker (.*);
